// ===== rtl/kcs_pkg.sv =====
// ----------------------------------------------------------------------------
// kcs_pkg
// shared types, mode codes and mode tables for the keccak sponge hash
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcs_pkg;

    localparam int LANE_W      = 64;
    localparam int LANE_COUNT  = 25;
    localparam int ROUND_COUNT = 24;
    localparam int MODE_W      = 3;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 4;
    localparam int LFSR_W      = 8;

    localparam logic [CNT_W-1:0]  BYTES_PER_WORD = 4'd8;
    localparam logic [LFSR_W-1:0] LFSR_FEEDBACK  = 8'h71;
    localparam logic [LFSR_W-1:0] LFSR_SEED      = 8'h01;
    localparam logic [7:0]        DOMAIN_SHA3    = 8'h06;
    localparam logic [7:0]        DOMAIN_SHAKE   = 8'h1f;
    localparam logic [LANE_W-1:0] PAD_TOP_BIT    = {1'b1, {(LANE_W-1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_SHA3_224 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SHA3_256 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHA3_384 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHA3_512 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHAKE128 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SHAKE256 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESET    = MODE_SHA3_256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERM_PRE,
        ST_ABSORB,
        ST_PERM_ABS,
        ST_PAD,
        ST_PERM_FIN,
        ST_SQUEEZE
    } kcs_state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic absorb;
        logic pad;
        logic out_adv;
        logic clear;
    } kcs_cmd_t;

    typedef struct packed {
        logic fill_ge_rate;
        logic absorb_fills;
        logic round_last;
        logic last_chunk;
        logic full_word;
        logic out_last;
    } kcs_status_t;

    // rate in lanes
    function automatic logic [IDX_W-1:0] mode_rate(input logic [MODE_W-1:0] m);
        logic [IDX_W-1:0] r;
        case (m)
            MODE_SHA3_224: r = 5'd18;
            MODE_SHA3_256: r = 5'd17;
            MODE_SHA3_384: r = 5'd13;
            MODE_SHA3_512: r = 5'd9;
            MODE_SHAKE128: r = 5'd21;
            default:       r = 5'd17;
        endcase
        return r;
    endfunction

    // digest length in words
    function automatic logic [IDX_W-1:0] mode_words(input logic [MODE_W-1:0] m);
        logic [IDX_W-1:0] w;
        case (m)
            MODE_SHA3_224: w = 5'd4;
            MODE_SHA3_256: w = 5'd4;
            MODE_SHA3_384: w = 5'd6;
            MODE_SHA3_512: w = 5'd8;
            MODE_SHAKE128: w = 5'd21;
            default:       w = 5'd17;
        endcase
        return w;
    endfunction

    // valid bytes in the final digest word
    function automatic logic [CNT_W-1:0] mode_tail_bytes(input logic [MODE_W-1:0] m);
        logic [CNT_W-1:0] b;
        case (m)
            MODE_SHA3_224: b = 4'd4;
            default:       b = BYTES_PER_WORD;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] mode_domain(input logic [MODE_W-1:0] m);
        logic [7:0] d;
        case (m)
            MODE_SHA3_224: d = DOMAIN_SHA3;
            MODE_SHA3_256: d = DOMAIN_SHA3;
            MODE_SHA3_384: d = DOMAIN_SHA3;
            MODE_SHA3_512: d = DOMAIN_SHA3;
            default:       d = DOMAIN_SHAKE;
        endcase
        return d;
    endfunction

    function automatic logic [LANE_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [LANE_W-1:0] m;
        m = '0;
        for (int b = 0; b < LANE_W / 8; b++)
        begin
            m[8*b +: 8] = {8{CNT_W'(b) < n}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcs_ctrl
// sequencer for absorb, padding, permutation rounds and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcs_ctrl
    import kcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire kcs_status_t st,
    output kcs_cmd_t         cmd
);

    kcs_state_t state_reg;
    kcs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.fill_ge_rate ? ST_PERM_PRE : ST_ABSORB;
                end
            end
            ST_PERM_PRE:
            begin
                if (st.round_last)
                begin
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (!st.last_chunk)
                begin
                    state_next = st.absorb_fills ? ST_PERM_ABS : ST_IDLE;
                end
                else if (st.full_word)
                begin
                    state_next = st.absorb_fills ? ST_PERM_ABS : ST_PAD;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PERM_ABS:
            begin
                if (st.round_last)
                begin
                    state_next = st.last_chunk ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                state_next = ST_PERM_FIN;
            end
            ST_PERM_FIN:
            begin
                if (st.round_last)
                begin
                    state_next = ST_SQUEEZE;
                end
            end
            ST_SQUEEZE:
            begin
                if (out_ready && st.out_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PERM_PRE, ST_PERM_ABS, ST_PERM_FIN:
            begin
                cmd.round = 1'b1;
            end
            ST_ABSORB:
            begin
                cmd.absorb = !st.last_chunk || st.full_word;
            end
            ST_PAD:
            begin
                cmd.pad = 1'b1;
            end
            ST_SQUEEZE:
            begin
                out_valid   = 1'b1;
                cmd.out_adv = out_ready;
                cmd.clear   = out_ready && st.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open at once");

    a_final_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PERM_FIN && st.round_last) |=> out_valid)
        else $error("digest not offered after final permutation");
`endif

endmodule

`default_nettype wire

// ===== rtl/kcs_datapath.sv =====
// ----------------------------------------------------------------------------
// kcs_datapath
// keccak state lanes, one round per cycle, round constant lfsr and counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcs_datapath
    import kcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [MODE_W-1:0] hash_mode,
    input  wire kcs_cmd_t          cmd,
    output kcs_status_t            st,
    input  wire logic [LANE_W-1:0] message_word,
    input  wire logic [CNT_W-1:0]  byte_count,
    input  wire logic              last_chunk,
    output logic [LANE_W-1:0]      digest_word,
    output logic [CNT_W-1:0]       digest_bytes,
    output logic                   format_error
);

    localparam int ROT [LANE_COUNT] = '{
        0, 1, 62, 28, 27,
        36, 44, 6, 55, 20,
        3, 10, 43, 25, 39,
        41, 45, 15, 21, 8,
        18, 2, 61, 56, 14
    };

    logic [LANE_W-1:0] lane_reg  [LANE_COUNT];
    logic [LANE_W-1:0] lane_next [LANE_COUNT];
    logic [LANE_W-1:0] round_out [LANE_COUNT];
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  round_idx_reg, round_idx_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              err_reg, err_next;
    logic [LANE_W-1:0] word_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  rate;
    logic [IDX_W-1:0]  fill_inc;
    logic [IDX_W-1:0]  rate_top;
    logic [CNT_W-1:0]  cnt_clamped;
    logic [7:0]        domain;
    logic [LANE_W-1:0] pad_word;
    logic              full_word;
    logic              round_last;
    logic              out_last;

    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] v, input int k);
        return (v << k) | (v >> (LANE_W - k));
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        return {l[LFSR_W-2:0], 1'b0} ^ (l[LFSR_W-1] ? LFSR_FEEDBACK : '0);
    endfunction

    function automatic logic [LANE_W-1:0] round_const(input logic [LFSR_W-1:0] l);
        logic [LANE_W-1:0] rc;
        logic [LFSR_W-1:0] s;
        rc = '0;
        s  = l;
        for (int j = 0; j < 7; j++)
        begin
            s = lfsr_step(s);
            if (s[1])
            begin
                rc[(1 << j) - 1] = 1'b1;
            end
        end
        return rc;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] l);
        logic [LFSR_W-1:0] s;
        s = l;
        for (int j = 0; j < 7; j++)
        begin
            s = lfsr_step(s);
        end
        return s;
    endfunction

    // one keccak-f round: theta, rho and pi, chi, iota
    always_comb
    begin
        logic [LANE_W-1:0] col [5];
        logic [LANE_W-1:0] dth [5];
        logic [LANE_W-1:0] rp  [LANE_COUNT];
        for (int x = 0; x < 5; x++)
        begin
            col[x] = lane_reg[x] ^ lane_reg[x+5] ^ lane_reg[x+10] ^ lane_reg[x+15]
                   ^ lane_reg[x+20];
        end
        for (int x = 0; x < 5; x++)
        begin
            dth[x] = col[(x + 4) % 5] ^ rotl(col[(x + 1) % 5], 1);
        end
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                rp[y + 5 * ((2 * x + 3 * y) % 5)] =
                    rotl(lane_reg[x + 5 * y] ^ dth[x], ROT[x + 5 * y]);
            end
        end
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                round_out[x + 5 * y] = rp[x + 5 * y]
                    ^ (~rp[(x + 1) % 5 + 5 * y] & rp[(x + 2) % 5 + 5 * y]);
            end
        end
        round_out[0] = round_out[0] ^ round_const(lfsr_reg);
    end

    assign rate        = mode_rate(hash_mode);
    assign rate_top    = rate - 5'd1;
    assign fill_inc    = fill_reg + 5'd1;
    assign domain      = mode_domain(hash_mode);
    assign full_word   = (cnt_reg == BYTES_PER_WORD);
    assign round_last  = (round_idx_reg == IDX_W'(ROUND_COUNT - 1));
    assign out_last    = (out_idx_reg == mode_words(hash_mode) - 5'd1);
    assign cnt_clamped = (byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : byte_count;
    assign pad_word    = full_word ? LANE_W'(domain)
                       : (word_reg | (LANE_W'(domain) << {cnt_reg[2:0], 3'b000}));

    assign st.fill_ge_rate = (fill_reg >= rate);
    assign st.absorb_fills = (fill_inc >= rate);
    assign st.round_last   = round_last;
    assign st.last_chunk   = last_reg;
    assign st.full_word    = full_word;
    assign st.out_last     = out_last;

    assign digest_bytes = out_last ? mode_tail_bytes(hash_mode) : BYTES_PER_WORD;
    assign digest_word  = lane_reg[out_idx_reg] & byte_mask(digest_bytes);
    assign format_error = err_reg;

    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            lane_next[i] = lane_reg[i];
            if (cmd.clear)
            begin
                lane_next[i] = '0;
            end
            else if (cmd.round)
            begin
                lane_next[i] = round_out[i];
            end
            else
            begin
                if (cmd.absorb && fill_reg == IDX_W'(i))
                begin
                    lane_next[i] = lane_next[i] ^ word_reg;
                end
                if (cmd.pad && fill_reg == IDX_W'(i))
                begin
                    lane_next[i] = lane_next[i] ^ pad_word;
                end
                if (cmd.pad && rate_top == IDX_W'(i))
                begin
                    lane_next[i] = lane_next[i] ^ PAD_TOP_BIT;
                end
            end
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        round_idx_next = round_idx_reg;
        lfsr_next      = lfsr_reg;
        out_idx_next   = out_idx_reg;
        err_next       = err_reg;
        if (cmd.round)
        begin
            round_idx_next = round_last ? '0 : round_idx_reg + 5'd1;
            lfsr_next      = round_last ? LFSR_SEED : lfsr_advance(lfsr_reg);
            if (round_last)
            begin
                fill_next = '0;
            end
        end
        if (cmd.absorb)
        begin
            fill_next = fill_inc;
            if (!last_reg && !full_word)
            begin
                err_next = 1'b1;
            end
        end
        if (cmd.out_adv)
        begin
            out_idx_next = out_idx_reg + 5'd1;
        end
        if (cmd.clear)
        begin
            fill_next    = '0;
            out_idx_next = '0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lane_reg[i] <= '0;
            end
            fill_reg      <= '0;
            round_idx_reg <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_idx_reg   <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lane_reg[i] <= lane_next[i];
            end
            fill_reg      <= fill_next;
            round_idx_reg <= round_idx_next;
            lfsr_reg      <= lfsr_next;
            out_idx_reg   <= out_idx_next;
            err_reg       <= err_next;
        end
    end

    // captured input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= message_word & byte_mask(cnt_clamped);
            cnt_reg  <= cnt_clamped;
            last_reg <= last_chunk;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (fill_reg == '0 && !err_reg && out_idx_reg == '0))
        else $error("run state not cleared after digest");

    a_round_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.round |=> ($stable(round_idx_reg) && $stable(lfsr_reg)))
        else $error("round counters moved outside a permutation");
`endif

endmodule

`default_nettype wire

// ===== rtl/keccak_sponge_hash.sv =====
// ----------------------------------------------------------------------------
// keccak_sponge_hash
// sha3 / shake sponge over keccak-f[1600], word in and digest words out
// ----------------------------------------------------------------------------
// A word that does not complete a rate block is captured and absorbed. A word
// that completes one adds a permutation, run one full round per cycle on the
// 25 state lanes. A last word is merged into the state, permuted if it
// completes a block, padded and permuted again; the digest then leaves one
// word per cycle while m_tready is high (4 to 21 words by mode). After reset
// the block is ready at once. The user must see that the mode register is
// written only while no message is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keccak_sponge_hash
    import kcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [MODE_W-1:0] cfg_wr_data,  // hash_mode
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [71:0]       s_tdata,      // message_word, byte_count
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [71:0]            m_tdata,      // digest_word, digest_bytes
    output logic                   m_tlast,
    output logic                   m_tuser       // format_error
);

    logic [MODE_W-1:0] hash_mode_reg;
    kcs_cmd_t          cmd;
    kcs_status_t       st;
    logic [LANE_W-1:0] digest_word;
    logic [CNT_W-1:0]  digest_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg <= MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            hash_mode_reg <= cfg_wr_data;
        end
    end

    kcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .st        (st),
        .cmd       (cmd)
    );

    kcs_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .hash_mode    (hash_mode_reg),
        .cmd          (cmd),
        .st           (st),
        .message_word (s_tdata[63:0]),
        .byte_count   (s_tdata[67:64]),
        .last_chunk   (s_tlast),
        .digest_word  (digest_word),
        .digest_bytes (digest_bytes),
        .format_error (m_tuser)
    );

    assign m_tdata = {4'b0000, digest_bytes, digest_word};
    assign m_tlast = st.out_last;

endmodule

`default_nettype wire

// ===== bench/keccak_sponge_checker.sv =====
// ----------------------------------------------------------------------------
// keccak_sponge_checker
// watches the config, message and digest channels of the keccak sponge hash,
// keeps its own sponge state, predicts every digest beat and compares each
// accepted beat, all fields at once, with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keccak_sponge_checker
    import kcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [MODE_W-1:0] cfg_wr_data,  // hash_mode
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [71:0]       s_tdata,      // message_word, byte_count
    input  wire logic              s_tlast,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [71:0]       m_tdata,      // digest_word, digest_bytes
    input  wire logic              m_tlast,
    input  wire logic              m_tuser,      // format_error
    output int                     pending,
    output int                     mismatches
);

    typedef struct packed {
        logic [LANE_W-1:0] word;
        logic [CNT_W-1:0]  nbytes;
        logic              last;
        logic              err;
    } digest_beat_t;

    digest_beat_t      digest_q [$];
    logic [LANE_W-1:0] lanes [LANE_COUNT];
    int                fill_pos;
    logic              sticky_err;
    logic [MODE_W-1:0] hash_mode;

    function automatic logic [LANE_W-1:0] low_bytes(input int n);
        if (n >= 8)
        begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic logic [LANE_W-1:0] rotl64(input logic [LANE_W-1:0] v, input int n);
        int k;
        k = n & 63;
        if (k == 0)
        begin
            return v;
        end
        return (v << k) | (v >> (LANE_W - k));
    endfunction

    function automatic void permute_lanes();
        logic [LANE_W-1:0] col [5];
        logic [LANE_W-1:0] row [5];
        logic [LANE_W-1:0] carry;
        logic [LANE_W-1:0] held;
        logic [LFSR_W-1:0] lfsr;
        int x, y, nx, rot;
        lfsr = LFSR_SEED;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            // theta
            for (x = 0; x < 5; x++)
            begin
                col[x] = '0;
                for (y = 0; y < 5; y++)
                begin
                    col[x] ^= lanes[x + 5 * y];
                end
            end
            for (x = 0; x < 5; x++)
            begin
                carry = col[(x + 4) % 5] ^ rotl64(col[(x + 1) % 5], 1);
                for (y = 0; y < 5; y++)
                begin
                    lanes[x + 5 * y] ^= carry;
                end
            end
            // rho and pi along the lane cycle
            carry = lanes[1];
            x = 1;
            y = 0;
            rot = 0;
            for (int j = 0; j < 24; j++)
            begin
                rot += j + 1;
                nx = y;
                y = (2 * x + 3 * y) % 5;
                x = nx;
                held = lanes[x + 5 * y];
                lanes[x + 5 * y] = rotl64(carry, rot & 63);
                carry = held;
            end
            // chi
            for (y = 0; y < 5; y++)
            begin
                for (x = 0; x < 5; x++)
                begin
                    row[x] = lanes[x + 5 * y];
                end
                for (x = 0; x < 5; x++)
                begin
                    lanes[x + 5 * y] = row[x] ^ (~row[(x + 1) % 5] & row[(x + 2) % 5]);
                end
            end
            // iota
            for (y = 0; y < 7; y++)
            begin
                lfsr = {lfsr[LFSR_W-2:0], 1'b0} ^ (lfsr[LFSR_W-1] ? LFSR_FEEDBACK : '0);
                if (lfsr[1])
                begin
                    lanes[0] ^= 64'd1 << ((1 << y) - 1);
                end
            end
        end
    endfunction

    function automatic void absorb_lane(input logic [LANE_W-1:0] w, input int rate);
        lanes[fill_pos] ^= w;
        fill_pos++;
        if (fill_pos >= rate)
        begin
            permute_lanes();
            fill_pos = 0;
        end
    endfunction

    function automatic void predict_digest(input logic [LANE_W-1:0] data,
                                           input logic [CNT_W-1:0] n_in,
                                           input logic is_last);
        logic [MODE_W-1:0] m;
        logic [7:0]        dom;
        logic [LANE_W-1:0] w;
        int                rate, dlen, nbytes, nwords, left;
        digest_beat_t      b;
        m = (hash_mode > MODE_SHAKE256) ? MODE_SHAKE256 : hash_mode;
        case (m)
            MODE_SHA3_224: begin rate = 18; dlen = 28;  dom = DOMAIN_SHA3;  end
            MODE_SHA3_256: begin rate = 17; dlen = 32;  dom = DOMAIN_SHA3;  end
            MODE_SHA3_384: begin rate = 13; dlen = 48;  dom = DOMAIN_SHA3;  end
            MODE_SHA3_512: begin rate = 9;  dlen = 64;  dom = DOMAIN_SHA3;  end
            MODE_SHAKE128: begin rate = 21; dlen = 168; dom = DOMAIN_SHAKE; end
            default:       begin rate = 17; dlen = 136; dom = DOMAIN_SHAKE; end
        endcase
        nbytes = (n_in > BYTES_PER_WORD) ? int'(BYTES_PER_WORD) : int'(n_in);
        w = data & low_bytes(nbytes);
        if (fill_pos >= rate)
        begin
            permute_lanes();
            fill_pos = 0;
        end
        if (!is_last)
        begin
            if (nbytes != int'(BYTES_PER_WORD))
            begin
                sticky_err = 1'b1;
            end
            absorb_lane(w, rate);
        end
        else
        begin
            if (nbytes == int'(BYTES_PER_WORD))
            begin
                absorb_lane(w, rate);
                lanes[fill_pos] ^= LANE_W'(dom);
            end
            else
            begin
                lanes[fill_pos] ^= w | (LANE_W'(dom) << (8 * nbytes));
            end
            lanes[rate - 1] ^= PAD_TOP_BIT;
            permute_lanes();
            nwords = (dlen + 7) / 8;
            for (int i = 0; i < nwords; i++)
            begin
                left = dlen - 8 * i;
                if (left > 8)
                begin
                    left = 8;
                end
                b.word   = lanes[i] & low_bytes(left);
                b.nbytes = CNT_W'(left);
                b.last   = (i + 1 == nwords);
                b.err    = sticky_err;
                digest_q.push_back(b);
            end
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lanes[i] = '0;
            end
            fill_pos = 0;
            sticky_err = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t exp_b;
        digest_beat_t act_b;
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lanes[i] = '0;
            end
            fill_pos = 0;
            sticky_err = 1'b0;
            hash_mode = MODE_RESET;
            digest_q.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act_b.word   = m_tdata[63:0];
                act_b.nbytes = m_tdata[67:64];
                act_b.last   = m_tlast;
                act_b.err    = m_tuser;
                if (digest_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected digest beat: word %h bytes %0d last %b err %b",
                                 act_b.word, act_b.nbytes, act_b.last, act_b.err);
                    end
                    mismatches++;
                end
                else
                begin
                    exp_b = digest_q.pop_front();
                    if (act_b !== exp_b)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("digest beat differs: exp word %h bytes %0d last %b err %b",
                                     exp_b.word, exp_b.nbytes, exp_b.last, exp_b.err);
                            $display("                     got word %h bytes %0d last %b err %b",
                                     act_b.word, act_b.nbytes, act_b.last, act_b.err);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_digest(s_tdata[63:0], s_tdata[67:64], s_tlast);
            end
            if (cfg_wr_en)
            begin
                hash_mode = cfg_wr_data;
            end
            pending <= digest_q.size();
        end
    end

endmodule

// ===== bench/tb_keccak_sponge_hash.sv =====
// ----------------------------------------------------------------------------
// tb_keccak_sponge_hash
// drives messages into the keccak sponge hash in every mode code, with random
// gaps and back pressure, and leaves prediction and checking to the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keccak_sponge_hash;
    import kcs_pkg::*;

    // codes six and seven alias shake256
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS  = 240;
    localparam int PHASES        = 10;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_NS      = 2000000;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [71:0]       m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    int                pending;
    int                mismatches;
    bit                idle_en;
    int                rx_hold_req;
    int                rx_hold_left;
    int                random_items;

    logic [MODE_W-1:0] phase_mode [PHASES] = '{
        MODE_SHA3_224, MODE_SHA3_512, MODE_SHAKE128, MODE_SHA3_384, MODE_SHAKE256,
        MODE_RSVD6, MODE_RSVD7, MODE_SHA3_256, MODE_SHAKE128, MODE_SHA3_512
    };

    keccak_sponge_hash u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    keccak_sponge_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // digest receiver
    initial
    begin
        m_tready = 1'b0;
        rx_hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                m_tready <= !(idle_en && $urandom_range(99) < 12);
            end
        end
    end

    task automatic send_beat(input logic [LANE_W-1:0] data, input logic [CNT_W-1:0] n,
                             input logic is_last);
        int gap;
        if (idle_en && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, n, data};
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int               target, rate, pick, nwords;
        bit               noisy;
        logic [CNT_W-1:0] cnt;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = MODE_RESET;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        idle_en      = 1'b1;
        rx_hold_req  = 0;
        random_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats in the reset mode
        send_beat('1, 4'd0, 1'b1);          // empty message, stray high bits
        send_beat('1, 4'd8, 1'b1);
        send_beat('0, 4'd15, 1'b1);         // count above eight
        send_beat('1, 4'd3, 1'b0);          // short word inside a message
        send_beat({$urandom, $urandom}, 4'd5, 1'b1);
        send_beat({$urandom, $urandom}, 4'd9, 1'b0);
        send_beat({$urandom, $urandom}, 4'd7, 1'b1);
        for (int i = 0; i < 16; i++)
        begin
            send_beat({$urandom, $urandom}, BYTES_PER_WORD, 1'b0);
        end
        send_beat({$urandom, $urandom}, BYTES_PER_WORD, 1'b1);  // last word fills the rate

        for (int p = 0; p < PHASES; p++)
        begin
            // mode change only once the block has drained
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_mode[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;

            idle_en = (p != 2);
            if (p == 5)
            begin
                rx_hold_req = HOLD_CYCLES;
            end
            target = RANDOM_ITEMS * (p + 1) / PHASES;
            rate = mode_rate(phase_mode[p]);
            while (random_items < target)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    nwords = $urandom_range(6);
                end
                else if (pick < 87)
                begin
                    nwords = rate - 2 + $urandom_range(3);
                end
                else
                begin
                    nwords = $urandom_range(2 * rate, rate + 1);
                end
                noisy = ($urandom_range(4) == 0);
                for (int i = 0; i < nwords; i++)
                begin
                    if (noisy && $urandom_range(2) == 0)
                    begin
                        cnt = CNT_W'($urandom_range(15));
                    end
                    else
                    begin
                        cnt = BYTES_PER_WORD;
                    end
                    send_beat({$urandom, $urandom}, cnt, 1'b0);
                end
                if ($urandom_range(7) == 0)
                begin
                    cnt = CNT_W'($urandom_range(15, 9));
                end
                else
                begin
                    cnt = CNT_W'($urandom_range(8));
                end
                send_beat({$urandom, $urandom}, cnt, 1'b1);
                random_items += nwords + 1;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kcs_pkg.sv
rtl/kcs_ctrl.sv
rtl/kcs_datapath.sv
rtl/keccak_sponge_hash.sv
bench/keccak_sponge_checker.sv
bench/tb_keccak_sponge_hash.sv
